// ===== design/stlb_pkg.sv =====
// ----------------------------------------------------------------------------
// stlb_pkg
// Shared constants for the set associative translation buffer.
// ----------------------------------------------------------------------------
package stlb_pkg;

    localparam int VA_BITS       = 32;
    localparam int IN_FRAME_BITS = 20;
    localparam int PHYS_BITS     = 27;
    localparam int NUM_SETS      = 4;
    localparam int SET_BITS      = 2;

    // slave tdata: virt_addr then frame, padded to whole bytes
    localparam int S_DATA_BITS = ((VA_BITS + IN_FRAME_BITS + 7) / 8) * 8;
    // master tdata: phys_addr padded to whole bytes
    localparam int M_DATA_BITS = ((PHYS_BITS + 7) / 8) * 8;

    // master tuser fields, highest bit first
    typedef struct packed {
        logic evicted;
        logic hit;
    } res_flags_t;

endpackage

// ===== design/set_assoc_tlb_lru_top.sv =====
// ----------------------------------------------------------------------------
// set_assoc_tlb_lru_top
// Four set translation buffer with age based replacement, lookup and fill.
// ----------------------------------------------------------------------------
// path: an input beat reaches its result beat through the input register,
// then tag compare and entry update into the result register
// throughput: one beat per cycle while m_tready does not stall the result; the entry
// update finishes in the same cycle as its compare, so the next beat sees it
// reset: all valid bits and ages clear at once; tags and frames are not reset
module set_assoc_tlb_lru_top #(
    parameter int PAGE_BYTES = 128,
    parameter int NUM_WAYS   = 4,
    parameter int FRAME_BITS = 20,
    parameter int AGE_BITS   = 8
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // virt_addr [31:0], frame [51:32], zero pad above
    input  logic [stlb_pkg::S_DATA_BITS-1:0]   s_tdata,
    // mode
    input  logic                               s_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // phys_addr [26:0], zero pad above
    output logic [stlb_pkg::M_DATA_BITS-1:0]   m_tdata,
    // hit [0], evicted [1]
    output stlb_pkg::res_flags_t               m_tuser
);
    import stlb_pkg::*;

    localparam int OFF_BITS = $clog2(PAGE_BYTES);
    localparam int TAG_BITS = VA_BITS - OFF_BITS - SET_BITS;
    localparam int WAY_BITS = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
    localparam int FW       = (FRAME_BITS < IN_FRAME_BITS) ? FRAME_BITS : IN_FRAME_BITS;
    localparam int PW       = FW + OFF_BITS;

    // input register
    logic                     in_valid_reg;
    logic                     mode_reg;
    logic [VA_BITS-1:0]       va_reg;
    logic [FW-1:0]            frame_reg;

    // result register
    logic                     out_valid_reg;
    logic                     hit_reg;
    logic                     evicted_reg;
    logic [PHYS_BITS-1:0]     phys_reg;

    // entry storage
    logic                     valid_reg [NUM_SETS][NUM_WAYS];
    logic [AGE_BITS-1:0]      age_reg   [NUM_SETS][NUM_WAYS];
    logic [TAG_BITS-1:0]      tag_reg   [NUM_SETS][NUM_WAYS];
    logic [FW-1:0]            frm_reg   [NUM_SETS][NUM_WAYS];

    logic                     work_fire;
    logic [SET_BITS-1:0]      set_idx;
    logic [TAG_BITS-1:0]      tag_in;
    logic [OFF_BITS-1:0]      off_in;

    logic                     hit_next;
    logic [WAY_BITS-1:0]      hit_way;
    logic [PHYS_BITS-1:0]     phys_next;
    logic                     seen_free;
    logic [WAY_BITS-1:0]      free_way;
    logic [WAY_BITS-1:0]      max_way;
    logic [AGE_BITS-1:0]      max_age;
    logic [WAY_BITS-1:0]      pick_way;
    logic [AGE_BITS-1:0]      aged [NUM_WAYS];
    logic [PW-1:0]            phys_cat;
    logic [PHYS_BITS+PW-1:0]  phys_wide;

    assign work_fire = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || work_fire;

    assign set_idx = va_reg[OFF_BITS +: SET_BITS];
    assign tag_in  = va_reg[VA_BITS-1 -: TAG_BITS];
    assign off_in  = va_reg[OFF_BITS-1:0];

    always_comb
    begin
        hit_next  = 1'b0;
        hit_way   = '0;
        phys_cat  = '0;
        seen_free = 1'b0;
        free_way  = '0;
        max_way   = '0;
        max_age   = '0;
        for (int w = 0; w < NUM_WAYS; w++)
        begin
            if (!hit_next && valid_reg[set_idx][w] && tag_reg[set_idx][w] == tag_in)
            begin
                hit_next = 1'b1;
                hit_way  = WAY_BITS'(w);
                phys_cat = {frm_reg[set_idx][w], off_in};
            end
        end
        // fill scan: age valid ways up to the first free one
        for (int w = 0; w < NUM_WAYS; w++)
        begin
            aged[w] = age_reg[set_idx][w];
            if (!seen_free)
            begin
                if (valid_reg[set_idx][w])
                begin
                    if (aged[w] != {AGE_BITS{1'b1}})
                        aged[w] = aged[w] + AGE_BITS'(1);
                end
                else
                begin
                    seen_free = 1'b1;
                    free_way  = WAY_BITS'(w);
                end
            end
        end
        // oldest way, ties to the lower way
        max_age = aged[0];
        for (int w = 1; w < NUM_WAYS; w++)
        begin
            if (aged[w] > max_age)
            begin
                max_age = aged[w];
                max_way = WAY_BITS'(w);
            end
        end
        pick_way  = seen_free ? free_way : max_way;
        phys_wide = {{PHYS_BITS{1'b0}}, phys_cat};
        phys_next = phys_wide[PHYS_BITS-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int s = 0; s < NUM_SETS; s++)
            begin
                for (int w = 0; w < NUM_WAYS; w++)
                begin
                    valid_reg[s][w] <= 1'b0;
                    age_reg[s][w]   <= '0;
                end
            end
        end
        else
        begin
            if (s_tready)
                in_valid_reg <= s_tvalid;
            if (work_fire)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
            if (work_fire)
            begin
                if (mode_reg)
                begin
                    for (int w = 0; w < NUM_WAYS; w++)
                        age_reg[set_idx][w] <= (WAY_BITS'(w) == pick_way) ? '0 : aged[w];
                    valid_reg[set_idx][pick_way] <= 1'b1;
                end
                else if (hit_next)
                begin
                    age_reg[set_idx][hit_way] <= '0;
                end
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            mode_reg  <= s_tuser;
            va_reg    <= s_tdata[VA_BITS-1:0];
            frame_reg <= s_tdata[VA_BITS +: FW];
        end
        if (work_fire)
        begin
            hit_reg     <= !mode_reg && hit_next;
            evicted_reg <= mode_reg && !seen_free;
            phys_reg    <= (!mode_reg && hit_next) ? phys_next : '0;
            if (mode_reg)
            begin
                tag_reg[set_idx][pick_way] <= tag_in;
                frm_reg[set_idx][pick_way] <= frame_reg;
            end
        end
    end

    assign m_tvalid        = out_valid_reg;
    assign m_tdata         = {{(M_DATA_BITS - PHYS_BITS){1'b0}}, phys_reg};
    assign m_tuser.hit     = hit_reg;
    assign m_tuser.evicted = evicted_reg;

endmodule
